>>> rtl/rmw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmw_pkg: shared types and constants for the robust weight core
// Mode codes, register indexes, sideband struct and fixed-point constants.
// ----------------------------------------------------------------------------
package rmw_pkg;

  localparam int RMW_FRAC_BITS = 16;
  localparam int RES_W         = 32;  // residual width
  localparam int TC_W          = 32;  // tuning constant width
  localparam int MODE_W        = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int MAG_W         = 33;  // |residual| holds 2^31
  localparam int NORM_W        = 19;  // normalized operands stay below 2^19
  localparam int SHIFT_W       = 4;   // normalizing shift 0..14
  localparam int SQ_W          = 2 * NORM_W;
  localparam int DEN_W         = SQ_W + 1;

  localparam int            Q30_W     = 31;
  localparam logic [30:0]   Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0]   LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0]   LN2_Q30   = 30'd744261118;
  localparam logic [31:0]   RECIP3    = 32'hAAAA_AAAB;  // floor(v/3) = v*RECIP3 >> 33

  typedef enum logic [MODE_W-1:0] {
    MODE_FAIR   = 3'd0,
    MODE_HUBER  = 3'd1,
    MODE_CAUCHY = 3'd2,
    MODE_TUKEY  = 3'd3,
    MODE_WELSH  = 3'd4
  } rmw_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 1'b0,
    REG_TUNING = 1'b1
  } rmw_reg_t;

  // Per-item control that rides along the datapath
  typedef struct packed {
    rmw_mode_t mode;
    logic      lt;   // |e| < c
    logic      gt;   // |e| > c
  } rmw_side_t;

endpackage

`default_nettype wire

>>> rtl/rmw_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmw_div: pipelined restoring divider
// One quotient bit per stage, sideband carried along, overflow flagged when
// the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module rmw_div
  import rmw_pkg::*;
#(
  parameter int NW  = RMW_FRAC_BITS + DEN_W,
  parameter int DW  = DEN_W,
  parameter int QW  = RMW_FRAC_BITS + 4,
  parameter int SBW = $bits(rmw_side_t)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_v,
  input  wire logic [NW-1:0]  in_num,
  input  wire logic [DW-1:0]  in_den,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_v,
  output logic [QW-1:0]       out_q,
  output logic                out_ovf,
  output logic [SBW-1:0]      out_sb
);

  localparam int HW = NW - QW;

  logic [QW:0]     v_r;
  logic [QW:0]     ovf_r;
  logic [DW-1:0]   rem_r [0:QW];
  logic [DW-1:0]   d_r   [0:QW];
  logic [QW-1:0]   lo_r  [0:QW];
  logic [QW-1:0]   q_r   [0:QW];
  logic [SBW-1:0]  sb_r  [0:QW];

  logic [HW-1:0]   hi;
  logic            ovf0;
  logic [DW:0]     r2 [0:QW-1];
  logic [DW:0]     df [0:QW-1];
  logic [QW-1:0]   ge;

  assign hi   = in_num[NW-1:QW];
  assign ovf0 = (HW+DW)'(hi) >= (HW+DW)'(in_den);

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      r2[j] = {rem_r[j], lo_r[j][QW-1]};
      df[j] = r2[j] - {1'b0, d_r[j]};
      ge[j] = r2[j] >= {1'b0, d_r[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(hi);
      d_r[0]   <= in_den;
      lo_r[0]  <= in_num[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= ovf0;
      sb_r[0]  <= in_sb;
      for (int j = 0; j < QW; j++) begin
        rem_r[j+1] <= ge[j] ? df[j][DW-1:0] : r2[j][DW-1:0];
        d_r[j+1]   <= d_r[j];
        lo_r[j+1]  <= lo_r[j] << 1;
        q_r[j+1]   <= {q_r[j][QW-2:0], ge[j]};
        ovf_r[j+1] <= ovf_r[j];
        sb_r[j+1]  <= sb_r[j];
      end
    end
  end

  assign out_v   = v_r[QW];
  assign out_q   = q_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_sb  = sb_r[QW];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QW] && !ovf_r[QW] && (d_r[QW] != '0) |-> rem_r[QW] < d_r[QW])
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> v_r == $past(v_r))
    else $error("divider valids moved while held");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> v_r[1] == $past(v_r[0]))
    else $error("divider valid lost while advancing");

endmodule

`default_nettype wire

>>> rtl/robust_mestimator_weight_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// robust_mestimator_weight_core: robust M-estimator weight
// Maps a signed Q16.16 residual to a Q1.16 weight under the Fair, Huber,
// Cauchy, Tukey or Welsh estimator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_residual: a residual transfers when
//   in_valid is high and in_stall is low. Output channel out_valid/out_stall/
//   out_robust_weight: one weight per residual, in order.
//   Config port cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 is the mode,
//   index 1 the tuning constant (zero acts as 1.0). cfg_ready is always high;
//   write only while no item is in flight.
//   The pipeline holds six setup stages, a restoring divider with
//   FRAC_BITS + 5 stages, ten stages for the Welsh exponential and
//   squaring, the final select register and the output register.
//   Throughput is one item per cycle while in_stall is low; the divider
//   takes one bit per stage.
//   Reset clears all valids and loads mode Huber with a constant of 1.0.
//   When the receiver stalls, the result holds in the output register, one
//   more lands in a skid register, and then in_stall rises and the whole
//   pipeline freezes until the output drains.
// ----------------------------------------------------------------------------
module robust_mestimator_weight_core
  import rmw_pkg::*;
#(
  parameter int FRAC_BITS = RMW_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [RES_W-1:0] in_residual,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [FRAC_BITS:0]         out_robust_weight,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [TC_W-1:0]       cfg_data
);

  localparam int F       = FRAC_BITS;
  localparam int W_W     = F + 1;
  localparam int QW      = F + 4;
  localparam int NW      = F + DEN_W;
  localparam int SQQ_W   = 2 * QW;
  localparam int ZW      = F + 7;
  localparam int YW      = ZW + 31;
  localparam int NPOST   = 10;
  localparam int SBW     = $bits(rmw_side_t);
  localparam logic [W_W-1:0]  ONE       = W_W'(1) << F;
  localparam logic [QW-1:0]   WELSH_MAX = QW'(8) << F;
  localparam logic [SQQ_W-1:0] HALF     = SQQ_W'(1) << (F - 1);
  localparam logic [Q30_W-1:0] RND      = Q30_W'(1) << (29 - F);

  // ---------------- configuration ----------------
  rmw_mode_t       mode_r;
  logic [TC_W-1:0] tc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUBER;
      tc_r   <= TC_W'(ONE);
    end else if (cfg_valid && cfg_ready) begin
      case (rmw_reg_t'(cfg_index))
        REG_MODE:   mode_r <= rmw_mode_t'(cfg_data[MODE_W-1:0]);
        REG_TUNING: tc_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_v_r, out_v_r;
  logic [W_W-1:0] skid_w_r, out_w_r;
  logic fin_v_r;
  logic [W_W-1:0] fin_w_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // ---------------- setup stages ----------------
  logic [MAG_W-1:0] res_sx, mag;
  logic [MAG_W-1:0] c_ext2, mx;
  logic [SHIFT_W-1:0] s2_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [MAG_W-1:0] a1_r, a2_r, a3_r, a4_r;
  logic [TC_W-1:0]  c1_r, c2_r, c3_r, c4_r;
  rmw_mode_t        m1_r;
  rmw_side_t        sd2_r, sd3_r, sd4_r, sd5_r, sd6_r;
  logic [SHIFT_W-1:0] s2_r;
  logic [NORM_W-1:0]  as3_r, cs3_r;
  logic [SQ_W-1:0]    asq4_r, csq4_r;
  logic [NW-1:0]      n5_nxt, n5_r, nsum6_r;
  logic [DEN_W-1:0]   d5_nxt, d5_r, d6_r;

  assign res_sx = {in_residual[RES_W-1], in_residual};
  assign mag    = in_residual[RES_W-1] ? (~res_sx + 1'b1) : res_sx;
  // Shift is found one stage early so it lands beside a2_r/c2_r
  assign c_ext2 = MAG_W'(c1_r);
  assign mx     = (a1_r > c_ext2) ? a1_r : c_ext2;

  always_comb begin
    s2_nxt = '0;
    for (int k = NORM_W; k < MAG_W; k++) begin
      if (mx[k]) s2_nxt = SHIFT_W'(k - NORM_W + 1);
    end
  end

  always_comb begin
    n5_nxt = '0;
    d5_nxt = '0;
    case (sd4_r.mode)
      MODE_FAIR: begin
        n5_nxt = NW'(c4_r) << F;
        d5_nxt = DEN_W'(a4_r) + DEN_W'(c4_r);
      end
      MODE_HUBER: begin
        n5_nxt = NW'(c4_r) << F;
        d5_nxt = DEN_W'(a4_r);
      end
      MODE_CAUCHY: begin
        n5_nxt = NW'(csq4_r) << F;
        d5_nxt = DEN_W'(csq4_r) + DEN_W'(asq4_r);
      end
      MODE_TUKEY: begin
        n5_nxt = NW'(csq4_r - asq4_r) << F;
        d5_nxt = DEN_W'(csq4_r);
      end
      MODE_WELSH: begin
        n5_nxt = NW'(a4_r) << F;
        d5_nxt = DEN_W'(c4_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && !in_stall;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r      <= mag;
      c1_r      <= (tc_r == '0) ? TC_W'(ONE) : tc_r;
      m1_r      <= mode_r;
      a2_r      <= a1_r;
      c2_r      <= c1_r;
      sd2_r.mode <= m1_r;
      sd2_r.lt  <= a1_r < MAG_W'(c1_r);
      sd2_r.gt  <= a1_r > MAG_W'(c1_r);
      s2_r      <= s2_nxt;
      a3_r      <= a2_r;
      c3_r      <= c2_r;
      sd3_r     <= sd2_r;
      as3_r     <= NORM_W'(a2_r >> s2_r);
      cs3_r     <= NORM_W'(c2_r >> s2_r);
      a4_r      <= a3_r;
      c4_r      <= c3_r;
      sd4_r     <= sd3_r;
      asq4_r    <= as3_r * as3_r;
      csq4_r    <= cs3_r * cs3_r;
      n5_r      <= n5_nxt;
      d5_r      <= d5_nxt;
      sd5_r     <= sd4_r;
      nsum6_r   <= n5_r + NW'(d5_r >> 1);
      d6_r      <= d5_r;
      sd6_r     <= sd5_r;
    end
  end

  // ---------------- divider ----------------
  logic            dq_v, dq_ovf;
  logic [QW-1:0]   dq_q;
  logic [SBW-1:0]  dq_sb;

  rmw_div #(
    .NW  (NW),
    .DW  (DEN_W),
    .QW  (QW),
    .SBW (SBW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v6_r),
    .in_num  (nsum6_r),
    .in_den  (d6_r),
    .in_sb   (sd6_r),
    .out_v   (dq_v),
    .out_q   (dq_q),
    .out_ovf (dq_ovf),
    .out_sb  (dq_sb)
  );

  // ---------------- post stages ----------------
  logic [NPOST-1:0] pv_r, pz_r;
  rmw_side_t        ps_r [0:NPOST-1];
  logic [W_W-1:0]   pw_r [0:NPOST-1];
  logic [4:0]       pi_r [0:NPOST-1];

  logic [SQQ_W-1:0] sq0_r;
  logic [ZW-1:0]    z1;
  logic [YW-1:0]    y1_r;
  logic [7:0]       i2;
  logic [59:0]      gl2_r;
  logic [26:0]      t3, t3_r, t4_r, t5_r;
  logic [Q30_W-1:0] p4, p3, p2, p7, p8, p9, p10;
  logic [57:0]      tm3_r, tm5_r, tm6_r;
  logic [59:0]      dv4_r;
  logic [61:0]      pp7_r, pp8_r, pp9_r;
  logic [Q30_W-1:0] r10;
  logic [W_W-1:0]   ww10, fin_nxt;

  assign z1  = ZW'((sq0_r + HALF) >> F);
  assign i2  = y1_r[YW-1:F+30];
  assign t3  = gl2_r[59:33];
  assign p4  = Q30_ONE - Q30_W'(t3 >> 2);
  assign p3  = Q30_ONE - Q30_W'(dv4_r[59:33]);
  assign p2  = Q30_ONE - Q30_W'(tm5_r[57:31]);
  assign p7  = Q30_ONE - Q30_W'(tm6_r[57:30]);
  assign p8  = pp7_r[60:30];
  assign p9  = pp8_r[60:30];
  assign p10 = pp9_r[60:30];
  assign r10 = p10 >> pi_r[NPOST-1];
  assign ww10 = W_W'((r10 + RND) >> (30 - F));

  always_comb begin
    case (ps_r[NPOST-1].mode)
      MODE_FAIR:   fin_nxt = pw_r[NPOST-1];
      MODE_CAUCHY: fin_nxt = pw_r[NPOST-1];
      MODE_HUBER:  fin_nxt = ps_r[NPOST-1].lt ? ONE : pw_r[NPOST-1];
      MODE_TUKEY:  fin_nxt = ps_r[NPOST-1].gt ? '0 : pw_r[NPOST-1];
      MODE_WELSH:  fin_nxt = pz_r[NPOST-1] ? '0 : ww10;
      default:     fin_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= '0;
      fin_v_r <= 1'b0;
    end else if (en) begin
      pv_r    <= {pv_r[NPOST-2:0], dq_v};
      fin_v_r <= pv_r[NPOST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r[0] <= rmw_side_t'(dq_sb);
      pw_r[0] <= dq_q[F:0];
      pz_r[0] <= dq_ovf || (dq_q > WELSH_MAX);
      pi_r[0] <= '0;
      for (int k = 1; k < NPOST; k++) begin
        ps_r[k] <= ps_r[k-1];
        // Tukey: square the ratio; Welsh: exponent scan
        if (k == 1 && ps_r[0].mode == MODE_TUKEY) begin
          pw_r[k] <= z1[F:0];
        end else begin
          pw_r[k] <= pw_r[k-1];
        end
        if (k == 2) begin
          pz_r[k] <= pz_r[1] || (i2 >= 8'd31);
          pi_r[k] <= i2[4:0];
        end else begin
          pz_r[k] <= pz_r[k-1];
          pi_r[k] <= pi_r[k-1];
        end
      end

      sq0_r <= dq_q * dq_q;
      y1_r  <= YW'(z1) * YW'(LOG2E_Q30);
      gl2_r <= y1_r[F+29:F] * LN2_Q30;
      t3_r  <= t3;
      tm3_r <= t3 * p4;
      t4_r  <= t3_r;
      dv4_r <= tm3_r[57:30] * RECIP3;
      t5_r  <= t4_r;
      tm5_r <= t4_r * p3;
      tm6_r <= t5_r * p2;
      pp7_r <= p7 * p7;
      pp8_r <= p8 * p8;
      pp9_r <= p9 * p9;
      fin_w_r <= fin_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || fin_v_r;
      skid_v_r <= 1'b0;
    end else if (en && fin_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_w_r <= skid_v_r ? skid_w_r : fin_w_r;
    end else if (en) begin
      skid_w_r <= fin_w_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_robust_weight = out_w_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while output register is empty");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_w_r <= ONE)
    else $error("weight above 1.0");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> fin_v_r == $past(fin_v_r))
    else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
